// ===== src/olb_pkg.sv =====
// ----------------------------------------------------------------------------
// olb_pkg
// Shared types and constants for the ordered list with bookmarks.
// ----------------------------------------------------------------------------
package olb_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = 6;
	localparam int CNT_W       = 7;
	localparam int DATA_BITS   = 32;
	localparam int MARK_COUNT  = 4;
	localparam int SEL_W       = 2;
	localparam int MARK_W      = 8;
	localparam int ERR_W       = 16;
	localparam int MODE_W      = 4;
	localparam int POS_W       = 8;

	localparam logic [MODE_W-1:0] MODE_PUSH   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 4'd1;
	localparam logic [MODE_W-1:0] MODE_DROP   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_SETMK  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_RDMK   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_MKFWD  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_MKBACK = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CLRERR = 4'd9;
	localparam logic [MODE_W-1:0] MODE_STATUS = 4'd10;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [POS_W-1:0]     position;
		logic [31:0]          data_word;
		logic [SEL_W-1:0]     mark_select;
		logic [MARK_W-1:0]    mark_value;
	} cmd_t;

	typedef struct packed {
		logic [31:0]          read_data;
		logic [CNT_W-1:0]     length_now;
		logic [MARK_W-1:0]    mark_now;
		logic                 mark_ok;
		logic                 rejected;
		logic [ERR_W-1:0]     full_errors;
		logic [ERR_W-1:0]     write_index_errors;
		logic [ERR_W-1:0]     read_index_errors;
	} res_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [DATA_BITS-1:0] wdata;
		logic                 re;
		logic [ADDR_W-1:0]    raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_RD,
		ST_FINISH
	} state_t;

endpackage

// ===== src/olb_store.sv =====
// ----------------------------------------------------------------------------
// olb_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olb_store import olb_pkg::*; (
	input  logic                 clk,
	input  mem_req_t             req,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== src/ordered_list_with_bookmarks.sv =====
// ----------------------------------------------------------------------------
// ordered_list_with_bookmarks
// Bounded ordered list of data words held in a memory, with bookmarks.
// ----------------------------------------------------------------------------
// Commands enter on in_word with in_valid/in_stall; each gives exactly one
// result word on out_word with out_valid/out_stall. The user writes max_length
// through cfg_write_en/cfg_write_data only while the block is idle; the
// block itself does not enforce this. It works on one command at a time;
// in_stall is high while busy. Commands that touch only registers go
// straight to the finish state; push writes its entry and read and read
// marked read their entry first. Insert and drop move each entry with a
// read state and then a write state, and insert then writes its entry.
// The result sits in an output register; the next command can be accepted
// while it waits. If the receiver still stalls when the next result is
// ready, the block holds that result and keeps in_stall high.
// Reset clears the count, bookmarks and error counters and sets max_length
// to 64; the entry memory is not cleared, as only entries below the count
// are ever read.
// ----------------------------------------------------------------------------
module ordered_list_with_bookmarks import olb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cmd_t               in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output res_t               out_word,
	input  logic               cfg_write_en,
	input  logic [CNT_W-1:0]   cfg_write_data
);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [CNT_W-1:0]  max_len_q;
	logic [CNT_W-1:0]  count_q;
	logic [MARK_W-1:0] mark_q [MARK_COUNT];
	logic [ERR_W-1:0]  full_err_q, wr_err_q, rd_err_q;
	logic [ADDR_W-1:0] idx_q, stop_q;
	logic              ins_q, hit_q, err_q;
	logic              out_valid_q;
	res_t              out_q;
	mem_req_t          req;
	logic [DATA_BITS-1:0] rdata;
	logic [ADDR_W-1:0] next_idx;

	logic [CNT_W-1:0]  limit;
	logic              accept, sel_ok, slot_free;
	logic [POS_W-1:0]  count_x, limit_x, ridx;
	logic [MARK_W-1:0] sel_mark;

	function automatic logic sel_ok_q();
		return 32'(cmd_q.mark_select) < MARK_COUNT;
	endfunction

	assign limit     = (max_len_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : max_len_q;
	assign count_x   = POS_W'(count_q);
	assign limit_x   = POS_W'(limit);
	assign accept    = in_valid && !in_stall;
	assign sel_ok    = 32'(in_word.mark_select) < MARK_COUNT;
	assign sel_mark  = mark_q[in_word.mark_select];
	assign ridx      = (in_word.mode == MODE_READ) ? in_word.position : sel_mark;
	assign slot_free = !out_valid_q || !out_stall;
	assign next_idx  = ins_q ? idx_q - 1'b1 : idx_q + 1'b1;

	olb_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_FINISH;
					case (in_word.mode)
						MODE_PUSH: begin
							if (count_q < limit) state_d = ST_PUT;
						end
						MODE_INSERT: begin
							if (count_q < limit && in_word.position <= count_x) begin
								state_d = (in_word.position == count_x) ? ST_PUT : ST_SHIFT_RD;
							end
						end
						MODE_DROP: begin
							if (in_word.position < count_x &&
							    in_word.position != count_x - 1'b1) begin
								state_d = ST_SHIFT_RD;
							end
						end
						MODE_READ, MODE_RDMK: begin
							if ((in_word.mode == MODE_READ || sel_ok) &&
							    ridx < limit_x && ridx < count_x) begin
								state_d = ST_RD;
							end
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: begin
				if (next_idx == stop_q) begin
					state_d = ins_q ? ST_PUT : ST_FINISH;
				end else begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_PUT:      state_d = ST_FINISH;
			ST_RD:       state_d = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		req       = '0;
		req.waddr = idx_q;
		req.raddr = idx_q;
		req.wdata = DATA_BITS'(cmd_q.data_word);
		case (state_q)
			ST_SHIFT_RD: begin
				req.re    = 1'b1;
				req.raddr = next_idx;
			end
			ST_SHIFT_WR: begin
				req.we    = 1'b1;
				req.wdata = rdata;
			end
			ST_PUT: req.we = 1'b1;
			ST_RD:  req.re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_len_q  <= CNT_W'(MAX_ENTRIES);
			count_q    <= '0;
			full_err_q <= '0;
			wr_err_q   <= '0;
			rd_err_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MARK_COUNT; i++) mark_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) max_len_q <= cfg_write_data;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_FINISH && slot_free) out_valid_q <= 1'b1;

			if (accept) begin
				case (in_word.mode)
					MODE_PUSH: begin
						if (count_q < limit) count_q <= count_q + 1'b1;
						else full_err_q <= full_err_q + 1'b1;
					end
					MODE_INSERT: begin
						if (count_q < limit && in_word.position <= count_x) begin
							count_q <= count_q + 1'b1;
							for (int i = 0; i < MARK_COUNT; i++) begin
								if (in_word.position < mark_q[i] && mark_q[i] != '1) begin
									mark_q[i] <= mark_q[i] + 1'b1;
								end
							end
						end else begin
							wr_err_q <= wr_err_q + 1'b1;
						end
					end
					MODE_DROP: begin
						if (in_word.position < count_x) begin
							count_q <= count_q - 1'b1;
							for (int i = 0; i < MARK_COUNT; i++) begin
								if (in_word.position < mark_q[i]) mark_q[i] <= mark_q[i] - 1'b1;
							end
						end else begin
							wr_err_q <= wr_err_q + 1'b1;
						end
					end
					MODE_READ, MODE_RDMK: begin
						if ((in_word.mode == MODE_READ || sel_ok) && ridx >= limit_x) begin
							rd_err_q <= rd_err_q + 1'b1;
						end
					end
					MODE_SETMK: begin
						if (sel_ok) mark_q[in_word.mark_select] <= in_word.mark_value;
					end
					MODE_MKFWD: begin
						if (sel_ok && sel_mark < count_x && sel_mark != '1) begin
							mark_q[in_word.mark_select] <= sel_mark + 1'b1;
						end
					end
					MODE_MKBACK: begin
						if (sel_ok && sel_mark != '0) begin
							mark_q[in_word.mark_select] <= sel_mark - 1'b1;
						end
					end
					MODE_CLEAR: begin
						count_q <= '0;
						for (int i = 0; i < MARK_COUNT; i++) mark_q[i] <= '0;
					end
					MODE_CLRERR: begin
						full_err_q <= '0;
						wr_err_q   <= '0;
						rd_err_q   <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Command context and sequencer pointers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_word;
			hit_q <= 1'b0;
			err_q <= 1'b0;
			ins_q <= (in_word.mode == MODE_INSERT);
			idx_q <= count_q[ADDR_W-1:0];
			stop_q <= in_word.position[ADDR_W-1:0];
			case (in_word.mode)
				MODE_PUSH:   err_q <= !(count_q < limit);
				MODE_INSERT: err_q <= !(count_q < limit && in_word.position <= count_x);
				MODE_DROP: begin
					err_q  <= !(in_word.position < count_x);
					idx_q  <= in_word.position[ADDR_W-1:0];
					stop_q <= ADDR_W'(count_q - 1'b1);
				end
				MODE_READ, MODE_RDMK: begin
					idx_q <= ridx[ADDR_W-1:0];
					if (in_word.mode == MODE_READ || sel_ok) begin
						err_q <= (ridx >= limit_x);
						hit_q <= (ridx < limit_x && ridx < count_x);
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_SHIFT_WR) begin
			idx_q <= next_idx;
		end

		if (state_q == ST_FINISH && slot_free) begin
			out_q.read_data          <= hit_q ? 32'(rdata) : '0;
			out_q.length_now         <= count_q;
			out_q.mark_now           <= sel_ok_q() ? mark_q[cmd_q.mark_select] : '0;
			out_q.mark_ok            <= sel_ok_q() &&
			                            (mark_q[cmd_q.mark_select] < POS_W'(count_q));
			out_q.rejected           <= err_q;
			out_q.full_errors        <= full_err_q;
			out_q.write_index_errors <= wr_err_q;
			out_q.read_index_errors  <= rd_err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !req.we && !req.re)
		else $error("memory access while idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second command taken while busy");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && slot_free |=> out_valid && state_q == ST_IDLE)
		else $error("finished result not presented");

endmodule

// ===== verif/tb_ordered_list_with_bookmarks.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_with_bookmarks
// Self-checking bench for the ordered list with bookmarks: directed commands
// cover the corner cases, then mostly well-formed random traffic runs against
// an in-bench predictor while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_ordered_list_with_bookmarks;
	import olb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	cmd_t             in_word;
	logic             out_valid;
	logic             out_stall;
	res_t             out_word;
	logic             cfg_write_en;
	logic [CNT_W-1:0] cfg_write_data;

	// Predictor state.
	logic [31:0]       list_mem [MAX_ENTRIES];
	int unsigned       list_len;
	int unsigned       marks [MARK_COUNT];
	logic [ERR_W-1:0]  full_cnt, wr_err_cnt, rd_err_cnt;
	int unsigned       len_limit_reg;

	res_t  expected_words [$];
	int    mismatch_count;
	int    cycle_count;
	bit    quiet_mode;

	ordered_list_with_bookmarks i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_word        (in_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_word       (out_word),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned len_limit();
		return (len_limit_reg < MAX_ENTRIES) ? len_limit_reg : MAX_ENTRIES;
	endfunction

	function automatic logic [31:0] list_read(int unsigned idx, ref bit err);
		if (idx >= len_limit()) begin
			rd_err_cnt = rd_err_cnt + 1'b1;
			err = 1'b1;
			return '0;
		end
		if (idx >= list_len)
			return '0;
		return list_mem[idx];
	endfunction

	function automatic res_t predict_list(cmd_t c);
		res_t r;
		bit err;
		bit sel_ok;
		logic [31:0] rdata;
		int unsigned pos, sel, mk;
		err = 1'b0;
		rdata = '0;
		pos = 32'(c.position);
		sel = 32'(c.mark_select);
		sel_ok = sel < MARK_COUNT;
		case (c.mode)
			MODE_PUSH: begin
				if (list_len < len_limit()) begin
					list_mem[list_len] = c.data_word;
					list_len++;
				end else begin
					full_cnt = full_cnt + 1'b1;
					err = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (list_len < len_limit() && pos <= list_len) begin
					for (int i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = c.data_word;
					list_len++;
					for (int i = 0; i < MARK_COUNT; i++)
						if (pos < marks[i] && marks[i] < 255)
							marks[i]++;
				end else begin
					wr_err_cnt = wr_err_cnt + 1'b1;
					err = 1'b1;
				end
			end
			MODE_DROP: begin
				if (pos < list_len) begin
					for (int i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					for (int i = 0; i < MARK_COUNT; i++)
						if (pos < marks[i])
							marks[i]--;
				end else begin
					wr_err_cnt = wr_err_cnt + 1'b1;
					err = 1'b1;
				end
			end
			MODE_READ:   rdata = list_read(pos, err);
			MODE_SETMK:  if (sel_ok) marks[sel] = 32'(c.mark_value);
			MODE_RDMK:   if (sel_ok) rdata = list_read(marks[sel], err);
			MODE_MKFWD: begin
				if (sel_ok && marks[sel] < list_len && marks[sel] < 255)
					marks[sel]++;
			end
			MODE_MKBACK: if (sel_ok && marks[sel] > 0) marks[sel]--;
			MODE_CLEAR: begin
				list_len = 0;
				foreach (marks[i]) marks[i] = 0;
			end
			MODE_CLRERR: begin
				full_cnt = '0;
				wr_err_cnt = '0;
				rd_err_cnt = '0;
			end
			default: ;
		endcase
		mk = sel_ok ? marks[sel] : 0;
		r.read_data = rdata;
		r.length_now = list_len[CNT_W-1:0];
		r.mark_now = mk[MARK_W-1:0];
		r.mark_ok = sel_ok && mk < list_len;
		r.rejected = err;
		r.full_errors = full_cnt;
		r.write_index_errors = wr_err_cnt;
		r.read_index_errors = rd_err_cnt;
		return r;
	endfunction

	function automatic bit idle_now();
		return !quiet_mode && $urandom_range(99) < 8;
	endfunction

	task automatic send_word(cmd_t c);
		while (idle_now())
			@(posedge clk);
		in_valid <= 1'b1;
		in_word <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_words.push_back(predict_list(c));
		in_valid <= 1'b0;
		// The block is busy in the cycle after it takes a word.
		@(posedge clk);
	endtask

	task automatic send_cmd(logic [MODE_W-1:0] m, int unsigned pos, logic [31:0] d,
			int unsigned sel, int unsigned mv);
		cmd_t c;
		c.mode = m;
		c.position = pos[POS_W-1:0];
		c.data_word = d;
		c.mark_select = sel[SEL_W-1:0];
		c.mark_value = mv[MARK_W-1:0];
		send_word(c);
	endtask

	task automatic drain_results();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_max_length(int unsigned v);
		drain_results();
		cfg_write_en <= 1'b1;
		cfg_write_data <= v[CNT_W-1:0];
		@(posedge clk);
		cfg_write_en <= 1'b0;
		len_limit_reg = v;
	endtask

	// Random command; list commands target valid positions most of the time.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int unsigned pick;
		c.data_word = $urandom;
		c.mark_select = SEL_W'($urandom_range(3));
		c.mark_value = ($urandom_range(3) == 0) ? MARK_W'($urandom_range(255))
			: MARK_W'($urandom_range(list_len + 1));
		c.position = ($urandom_range(9) == 0) ? POS_W'($urandom_range(255))
			: POS_W'($urandom_range(list_len + 1));
		pick = $urandom_range(99);
		if (pick < 25)      c.mode = MODE_PUSH;
		else if (pick < 40) c.mode = MODE_INSERT;
		else if (pick < 55) c.mode = MODE_DROP;
		else if (pick < 67) c.mode = MODE_READ;
		else if (pick < 72) c.mode = MODE_SETMK;
		else if (pick < 78) c.mode = MODE_RDMK;
		else if (pick < 84) c.mode = MODE_MKFWD;
		else if (pick < 90) c.mode = MODE_MKBACK;
		else if (pick < 92) c.mode = MODE_CLEAR;
		else if (pick < 94) c.mode = MODE_CLRERR;
		else                c.mode = MODE_W'($urandom_range(15));
		return c;
	endfunction

	task automatic test_directed();
		send_cmd(MODE_READ, 0, 0, 0, 0);
		send_cmd(MODE_DROP, 0, 0, 0, 0);
		send_cmd(MODE_PUSH, 0, 32'hFFFF_FFFF, 0, 0);
		send_cmd(MODE_PUSH, 0, 32'h0000_0000, 1, 0);
		send_cmd(MODE_INSERT, 0, 32'hA5A5_5A5A, 0, 0);
		send_cmd(MODE_INSERT, 5, 32'h1, 0, 0);
		send_cmd(MODE_SETMK, 0, 0, 0, 1);
		send_cmd(MODE_SETMK, 0, 0, 1, 255);
		send_cmd(MODE_SETMK, 0, 0, 2, 3);
		send_cmd(MODE_INSERT, 1, 32'h1234_5678, 0, 0);
		send_cmd(MODE_INSERT, 0, 32'h8765_4321, 1, 0);
		send_cmd(MODE_RDMK, 0, 0, 0, 0);
		send_cmd(MODE_RDMK, 0, 0, 1, 0);
		send_cmd(MODE_MKFWD, 0, 0, 2, 0);
		send_cmd(MODE_MKFWD, 0, 0, 2, 0);
		send_cmd(MODE_MKBACK, 0, 0, 3, 0);
		send_cmd(MODE_DROP, 0, 0, 2, 0);
		send_cmd(MODE_READ, 3, 0, 0, 0);
		send_cmd(MODE_READ, 63, 0, 0, 0);
		send_cmd(MODE_READ, 255, 0, 0, 0);
		send_cmd(MODE_RDMK, 0, 0, 1, 0);
		send_cmd(MODE_STATUS, 0, 0, 3, 0);
		send_cmd(4'd15, 8'hAA, 32'h5555_AAAA, 2, 8'h55);
		send_cmd(MODE_CLRERR, 0, 0, 0, 0);
		send_cmd(MODE_CLEAR, 0, 0, 1, 0);
	endtask

	// Fill to the limit, push past it, shrink the limit under the count, then set it above capacity.
	task automatic test_limits();
		write_max_length(3);
		repeat (5) send_cmd(MODE_PUSH, 0, $urandom, 0, 0);
		send_cmd(MODE_INSERT, 0, $urandom, 0, 0);
		send_cmd(MODE_READ, 3, 0, 0, 0);
		write_max_length(1);
		send_cmd(MODE_PUSH, 0, $urandom, 0, 0);
		send_cmd(MODE_READ, 2, 0, 0, 0);
		send_cmd(MODE_DROP, 0, 0, 0, 0);
		write_max_length(0);
		send_cmd(MODE_PUSH, 0, $urandom, 0, 0);
		send_cmd(MODE_READ, 0, 0, 0, 0);
		write_max_length(127);
		repeat (66) send_cmd(MODE_PUSH, 0, $urandom, 0, 0);
		send_cmd(MODE_INSERT, 10, $urandom, 0, 0);
		send_cmd(MODE_READ, 63, 0, 0, 0);
		send_cmd(MODE_READ, 64, 0, 0, 0);
		repeat (8) send_cmd(MODE_DROP, $urandom_range(55), 0, 0, 0);
	endtask

	task automatic test_random(int unsigned n, int unsigned limit_v);
		write_max_length(limit_v);
		for (int i = 0; i < n; i++) begin
			quiet_mode = (i >= n / 3) && (i < n / 2);
			send_word(random_cmd());
			// The sender waits here once for every result to come back.
			if (i == n / 4)
				while (expected_words.size() != 0)
					@(posedge clk);
		end
		quiet_mode = 1'b0;
	endtask

	// Result checker and receiver-side stall.
	always @(posedge clk) begin
		res_t exp_w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Unexpected result word %h", out_word);
				end else begin
					exp_w = expected_words.pop_front();
					if (out_word !== exp_w) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("Mismatch: expected %h actual %h", exp_w, out_word);
					end
				end
			end
			out_stall <= idle_now();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		mismatch_count = 0;
		cycle_count = 0;
		quiet_mode = 1'b0;
		list_len = 0;
		foreach (marks[i]) marks[i] = 0;
		foreach (list_mem[i]) list_mem[i] = '0;
		full_cnt = '0;
		wr_err_cnt = '0;
		rd_err_cnt = '0;
		len_limit_reg = 64;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_random(200, 64);
		test_random(100, 5);
		test_random(200, 100);
		drain_results();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/olb_pkg.sv
src/olb_store.sv
src/ordered_list_with_bookmarks.sv
verif/tb_ordered_list_with_bookmarks.sv
